/* sv/sidelink_subframe_pool_mapper_top_macros.svh */
// Assertion macros shared by the sidelink subframe pool mapper RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SIDELINK_SUBFRAME_POOL_MAPPER_TOP_MACROS_SVH
`define SIDELINK_SUBFRAME_POOL_MAPPER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSPM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sspm_pkg.sv */
// Shared constants and types for the sidelink subframe pool mapper.
// Used by the channel interfaces, the divider and the top level.
`default_nettype none

package sspm_pkg;

    localparam int FRAME_SPAN  = 10240;
    localparam int SYNC_PERIOD = 160;
    localparam int BITMAP_MAX  = 100;
    localparam int BITMAP_LO_W = 64;
    localparam int BITMAP_HI_W = BITMAP_MAX - BITMAP_LO_W;
    localparam int PSSCH_MOD   = 10;

    localparam int SF_W    = 14;
    localparam int PHASE_W = 8;
    localparam int LEN_W   = 7;
    localparam int KMOD_W  = 4;
    localparam int IDX_W   = 15;
    localparam int DATA_W  = 64;
    localparam int CFG_IDX_W = 2;

    // Dividend of the shared divider: up to 99 times the non-sync total.
    localparam int DIVD_W = LEN_W + SF_W;
    localparam int CNT_W  = $clog2(DIVD_W + 1);

    // Non-sync subframes in a span, before the correction for a partial period.
    localparam int NS_BASE  = FRAME_SPAN - FRAME_SPAN / SYNC_PERIOD;
    localparam int SPAN_REM = FRAME_SPAN % SYNC_PERIOD;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_OFFSET = 2'd0,
        CFG_BITMAP_LEN  = 2'd1,
        CFG_BITMAP_LOW  = 2'd2,
        CFG_BITMAP_HIGH = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [LEN_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [LEN_W-1:0]  remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

/* sv/sspm_tick_if.sv */
// Subframe tick channel of the sidelink subframe pool mapper.
// Depends on sspm_pkg.
`default_nettype none

interface sspm_tick_if
    import sspm_pkg::*;
();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

/* sv/sspm_result_if.sv */
// Result channel of the sidelink subframe pool mapper.
// Depends on sspm_pkg.
`default_nettype none

interface sspm_result_if
    import sspm_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [SF_W-1:0]         system_subframe;
    logic                    in_pool;
    logic signed [IDX_W-1:0] pool_index;
    logic [KMOD_W-1:0]       pssch_subframe;

    modport source (output valid, output system_subframe, output in_pool,
                    output pool_index, output pssch_subframe, input ready);
    modport sink (input valid, input system_subframe, input in_pool,
                  input pool_index, input pssch_subframe, output ready);
endinterface

`default_nettype wire

/* sv/sspm_cfg_if.sv */
// Configuration write channel of the sidelink subframe pool mapper.
// Depends on sspm_pkg.
`default_nettype none

interface sspm_cfg_if
    import sspm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/sidelink_subframe_pool_mapper_top.sv */
// Sidelink subframe pool mapper: one request on the tick channel per system subframe,
// one result per tick on the result channel; registers are written on the cfg channel.
// Setting restart marks the tick as subframe 0 and clears every counter; the span
// wraps by itself after subframe 10239.
// Each tick runs a 21-step restoring division for N_res = non-sync total mod bitmap
// length, then a decision state. A tick that hits a reserved position runs a second
// 21-step division for the next reserved position. Every tick ends by loading its
// result into the output register. tick.ready is high only while the sequencer is
// idle, so a new tick is not accepted until the previous one has loaded its result.
// The result sits in an output register: the next tick is accepted while it waits,
// and a stalled receiver holds up only the final load of the following tick.
// Reset clears all counters and sets the registers to sync_offset 0, bitmap_len 16,
// bitmap_low 0 and bitmap_high 0. The cfg channel is always ready and should be
// written only while no tick is in flight.
// Depends on sspm_pkg, the channel interfaces, sspm_div and the assertion macros.
`default_nettype none

`include "sidelink_subframe_pool_mapper_top_macros.svh"

module sidelink_subframe_pool_mapper_top
    import sspm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sspm_tick_if.sink   tick,
    sspm_result_if.source result,
    sspm_cfg_if.sink    cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_DECIDE,
        ST_RES,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [PHASE_W-1:0]     sync_offset_reg, sync_offset_next;
    logic [LEN_W-1:0]       bitmap_len_reg, bitmap_len_next;
    logic [BITMAP_LO_W-1:0] bitmap_low_reg, bitmap_low_next;
    logic [BITMAP_HI_W-1:0] bitmap_high_reg, bitmap_high_next;

    logic [SF_W-1:0]    sf_count_reg, sf_count_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [SF_W-1:0]    nonsync_reg, nonsync_next;
    logic [LEN_W-1:0]   rc_reg, rc_next;
    logic [SF_W-1:0]    next_res_reg, next_res_next;
    logic [LEN_W-1:0]   bitmap_pos_reg, bitmap_pos_next;
    logic [SF_W-1:0]    pool_count_reg, pool_count_next;
    logic [KMOD_W-1:0]  pool_mod_reg, pool_mod_next;
    logic [LEN_W-1:0]   n_res_reg, n_res_next;

    logic              res_pool_reg, res_pool_next;
    logic [SF_W-1:0]   res_k_reg, res_k_next;
    logic [KMOD_W-1:0] res_kmod_reg, res_kmod_next;

    logic                    out_valid_reg, out_valid_next;
    logic [SF_W-1:0]         out_sf_reg, out_sf_next;
    logic                    out_pool_reg, out_pool_next;
    logic signed [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [KMOD_W-1:0]       out_kmod_reg, out_kmod_next;

    logic [LEN_W-1:0]      eff_len;
    logic [PHASE_W-1:0]    eff_off;
    logic [SF_W-1:0]       ns_total;
    logic [BITMAP_MAX-1:0] bitmap;
    logic                  bitmap_hit;
    logic [LEN_W-1:0]      rc_plus;
    logic                  reserve_now;

    div_req_t div_req;
    div_rsp_t div_rsp;

    sspm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        if (bitmap_len_reg == '0)
            eff_len = LEN_W'(1);
        else if (bitmap_len_reg > LEN_W'(BITMAP_MAX))
            eff_len = LEN_W'(BITMAP_MAX);
        else
            eff_len = bitmap_len_reg;

        // The raw offset is below twice the period, so one subtraction wraps it.
        if (sync_offset_reg >= PHASE_W'(SYNC_PERIOD))
            eff_off = sync_offset_reg - PHASE_W'(SYNC_PERIOD);
        else
            eff_off = sync_offset_reg;

        ns_total = SF_W'(NS_BASE) - SF_W'(eff_off < PHASE_W'(SPAN_REM));

        bitmap     = {bitmap_high_reg, bitmap_low_reg};
        bitmap_hit = (bitmap_pos_reg < LEN_W'(BITMAP_MAX)) ? bitmap[bitmap_pos_reg] : 1'b0;
        rc_plus    = rc_reg + LEN_W'(1);

        reserve_now = (n_res_reg != '0) && (rc_reg < n_res_reg) &&
                      (nonsync_reg == next_res_reg);
    end

    always_comb
    begin
        state_next       = state_reg;
        sync_offset_next = sync_offset_reg;
        bitmap_len_next  = bitmap_len_reg;
        bitmap_low_next  = bitmap_low_reg;
        bitmap_high_next = bitmap_high_reg;
        sf_count_next    = sf_count_reg;
        phase_next       = phase_reg;
        nonsync_next     = nonsync_reg;
        rc_next          = rc_reg;
        next_res_next    = next_res_reg;
        bitmap_pos_next  = bitmap_pos_reg;
        pool_count_next  = pool_count_reg;
        pool_mod_next    = pool_mod_reg;
        n_res_next       = n_res_reg;
        res_pool_next    = res_pool_reg;
        res_k_next       = res_k_reg;
        res_kmod_next    = res_kmod_reg;
        out_valid_next   = out_valid_reg;
        out_sf_next      = out_sf_reg;
        out_pool_next    = out_pool_reg;
        out_idx_next     = out_idx_reg;
        out_kmod_next    = out_kmod_reg;
        div_req.start    = 1'b0;
        div_req.dividend = DIVD_W'(ns_total);
        div_req.divisor  = eff_len;

        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_SYNC_OFFSET: sync_offset_next = cfg.data[PHASE_W-1:0];
                CFG_BITMAP_LEN:  bitmap_len_next  = cfg.data[LEN_W-1:0];
                CFG_BITMAP_LOW:  bitmap_low_next  = cfg.data[BITMAP_LO_W-1:0];
                CFG_BITMAP_HIGH: bitmap_high_next = cfg.data[BITMAP_HI_W-1:0];
                default: ;
            endcase
        end

        if (result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (tick.valid)
                begin
                    if (tick.restart || (sf_count_reg >= SF_W'(FRAME_SPAN)))
                    begin
                        sf_count_next   = '0;
                        phase_next      = '0;
                        nonsync_next    = '0;
                        rc_next         = '0;
                        next_res_next   = '0;
                        bitmap_pos_next = '0;
                        pool_count_next = '0;
                        pool_mod_next   = '0;
                    end
                    div_req.start = 1'b1;
                    state_next    = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (div_rsp.done)
                begin
                    n_res_next = div_rsp.remainder;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                res_pool_next = 1'b0;
                res_k_next    = '0;
                res_kmod_next = '0;
                state_next    = ST_FINISH;
                if (phase_reg != eff_off)
                begin
                    nonsync_next = nonsync_reg + SF_W'(1);
                    if (reserve_now)
                    begin
                        rc_next          = rc_plus;
                        div_req.start    = 1'b1;
                        div_req.dividend = DIVD_W'(rc_plus) * DIVD_W'(ns_total);
                        div_req.divisor  = n_res_reg;
                        state_next       = ST_RES;
                    end
                    else
                    begin
                        if (bitmap_hit)
                        begin
                            res_pool_next   = 1'b1;
                            res_k_next      = pool_count_reg;
                            res_kmod_next   = pool_mod_reg;
                            pool_count_next = pool_count_reg + SF_W'(1);
                            if (pool_mod_reg == KMOD_W'(PSSCH_MOD - 1))
                                pool_mod_next = '0;
                            else
                                pool_mod_next = pool_mod_reg + KMOD_W'(1);
                        end
                        if ({1'b0, bitmap_pos_reg} + (LEN_W+1)'(1) >= {1'b0, eff_len})
                            bitmap_pos_next = '0;
                        else
                            bitmap_pos_next = bitmap_pos_reg + LEN_W'(1);
                    end
                end
            end
            ST_RES:
            begin
                if (div_rsp.done)
                begin
                    next_res_next = div_rsp.quotient[SF_W-1:0];
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_sf_next    = sf_count_reg;
                    out_pool_next  = res_pool_reg;
                    out_idx_next   = res_pool_reg ? $signed({1'b0, res_k_reg}) : '1;
                    out_kmod_next  = res_kmod_reg;
                    if (sf_count_reg + SF_W'(1) >= SF_W'(FRAME_SPAN))
                    begin
                        sf_count_next   = '0;
                        phase_next      = '0;
                        nonsync_next    = '0;
                        rc_next         = '0;
                        next_res_next   = '0;
                        bitmap_pos_next = '0;
                        pool_count_next = '0;
                        pool_mod_next   = '0;
                    end
                    else
                    begin
                        sf_count_next = sf_count_reg + SF_W'(1);
                        if (phase_reg == PHASE_W'(SYNC_PERIOD - 1))
                            phase_next = '0;
                        else
                            phase_next = phase_reg + PHASE_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sync_offset_reg <= '0;
            bitmap_len_reg  <= LEN_W'(16);
            bitmap_low_reg  <= '0;
            bitmap_high_reg <= '0;
            sf_count_reg    <= '0;
            phase_reg       <= '0;
            nonsync_reg     <= '0;
            rc_reg          <= '0;
            next_res_reg    <= '0;
            bitmap_pos_reg  <= '0;
            pool_count_reg  <= '0;
            pool_mod_reg    <= '0;
            n_res_reg       <= '0;
            res_pool_reg    <= 1'b0;
            res_k_reg       <= '0;
            res_kmod_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_sf_reg      <= '0;
            out_pool_reg    <= 1'b0;
            out_idx_reg     <= '0;
            out_kmod_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            sync_offset_reg <= sync_offset_next;
            bitmap_len_reg  <= bitmap_len_next;
            bitmap_low_reg  <= bitmap_low_next;
            bitmap_high_reg <= bitmap_high_next;
            sf_count_reg    <= sf_count_next;
            phase_reg       <= phase_next;
            nonsync_reg     <= nonsync_next;
            rc_reg          <= rc_next;
            next_res_reg    <= next_res_next;
            bitmap_pos_reg  <= bitmap_pos_next;
            pool_count_reg  <= pool_count_next;
            pool_mod_reg    <= pool_mod_next;
            n_res_reg       <= n_res_next;
            res_pool_reg    <= res_pool_next;
            res_k_reg       <= res_k_next;
            res_kmod_reg    <= res_kmod_next;
            out_valid_reg   <= out_valid_next;
            out_sf_reg      <= out_sf_next;
            out_pool_reg    <= out_pool_next;
            out_idx_reg     <= out_idx_next;
            out_kmod_reg    <= out_kmod_next;
        end
    end

    assign tick.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;

    assign result.valid           = out_valid_reg;
    assign result.system_subframe = out_sf_reg;
    assign result.in_pool         = out_pool_reg;
    assign result.pool_index      = out_idx_reg;
    assign result.pssch_subframe  = out_kmod_reg;

    `SSPM_ASSERT_SAME(a_div_done_waited, div_rsp.done,
        state_reg == ST_MOD || state_reg == ST_RES,
        "divider finished while the sequencer was not waiting for it")
    `SSPM_ASSERT_SAME(a_pool_fields, result.valid && !result.in_pool,
        result.pool_index == '1 && result.pssch_subframe == '0,
        "subframe outside the pool carries a pool index")
    `SSPM_ASSERT_SAME(a_pssch_range, result.valid && result.in_pool,
        result.pssch_subframe < KMOD_W'(PSSCH_MOD) && !result.pool_index[IDX_W-1],
        "pool subframe result out of range")
    `SSPM_ASSERT_NEXT(a_phase_follows, state_reg == ST_FINISH && state_next == ST_IDLE,
        phase_reg < PHASE_W'(SYNC_PERIOD) && sf_count_reg < SF_W'(FRAME_SPAN),
        "subframe counters left their span")

endmodule

`default_nettype wire

/* sv/sspm_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the mapper sequencer.
// Depends on sspm_pkg for widths and the request and response structs.
`default_nettype none

module sspm_div
    import sspm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [DIVD_W-1:0] quo_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [LEN_W:0] rem_shift;
    logic           fits;
    logic [LEN_W:0] rem_step;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVD_W-1]};
        fits      = (rem_shift >= {1'b0, dsr_reg});
        rem_step  = fits ? (rem_shift - {1'b0, dsr_reg}) : rem_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            quo_reg  <= req.dividend;
            rem_reg  <= '0;
            dsr_reg  <= req.divisor;
            cnt_reg  <= CNT_W'(DIVD_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            // The partial remainder always stays below the divisor, so it fits.
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
            rem_reg <= rem_step[LEN_W-1:0];
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the sidelink subframe pool mapper (sidelink_subframe_pool_mapper_top).
// Drives subframe ticks and register writes, predicts each subframe's pool mapping and checks it.
// Depends on sspm_pkg, the three channel interfaces and the top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sspm_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_TICKS   = 1350;

    typedef struct packed {
        logic [SF_W-1:0]         system_subframe;
        logic                    in_pool;
        logic signed [IDX_W-1:0] pool_index;
        logic [KMOD_W-1:0]       pssch_subframe;
    } subframe_map_t;

    // Tracks the mapper's counters and registers, and holds the mappings still to arrive.
    class pool_map_checker;
        logic [7:0]  sync_offset;
        logic [6:0]  bitmap_len;
        logic [63:0] bitmap_low;
        logic [35:0] bitmap_high;

        int unsigned subframe_count;
        int unsigned nonsync_count;
        int unsigned reserved_count;
        int unsigned next_reserved;
        int unsigned bitmap_pos;
        int unsigned pool_count;

        subframe_map_t pending_maps[$];
        int unsigned   map_errors;

        function new();
            sync_offset = 0;
            bitmap_len  = 16;
            bitmap_low  = '0;
            bitmap_high = '0;
            map_errors  = 0;
            clear_counters();
        endfunction

        function void clear_counters();
            subframe_count = 0;
            nonsync_count  = 0;
            reserved_count = 0;
            next_reserved  = 0;
            bitmap_pos     = 0;
            pool_count     = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [DATA_W-1:0] value);
            case (idx)
                CFG_SYNC_OFFSET: sync_offset = value[7:0];
                CFG_BITMAP_LEN:  bitmap_len  = value[6:0];
                CFG_BITMAP_LOW:  bitmap_low  = value;
                CFG_BITMAP_HIGH: bitmap_high = value[BITMAP_HI_W-1:0];
                default: ;
            endcase
        endfunction

        // Works out the mapping of one accepted tick and queues it.
        function void map_tick(logic restart);
            int unsigned   sf, len, offset, ns_total, n_res, k;
            bit            pool, usable, skip;
            subframe_map_t want;
            if (restart || subframe_count >= FRAME_SPAN)
                clear_counters();
            sf = subframe_count;
            len = (bitmap_len == 0) ? 1 : (bitmap_len > BITMAP_MAX) ? BITMAP_MAX : bitmap_len;
            offset = sync_offset % SYNC_PERIOD;
            ns_total = FRAME_SPAN - FRAME_SPAN / SYNC_PERIOD;
            if (offset < FRAME_SPAN % SYNC_PERIOD)
                ns_total = ns_total - 1;
            n_res = ns_total % len;
            pool = 0;
            k = 0;
            if (sf % SYNC_PERIOD != offset)
            begin
                skip = (n_res != 0) && (reserved_count < n_res) &&
                       (nonsync_count == next_reserved);
                if (skip)
                begin
                    reserved_count = reserved_count + 1;
                    next_reserved = (reserved_count * ns_total) / n_res;
                end
                else
                begin
                    // Bits at 100 and above read as zero.
                    if (bitmap_pos < BITMAP_LO_W)
                        usable = bitmap_low[bitmap_pos];
                    else if (bitmap_pos < BITMAP_MAX)
                        usable = bitmap_high[bitmap_pos - BITMAP_LO_W];
                    else
                        usable = 0;
                    if (usable)
                    begin
                        pool = 1;
                        k = pool_count;
                        pool_count = pool_count + 1;
                    end
                    bitmap_pos = (bitmap_pos + 1 >= len) ? 0 : bitmap_pos + 1;
                end
                nonsync_count = nonsync_count + 1;
            end
            subframe_count = sf + 1;
            if (subframe_count >= FRAME_SPAN)
                clear_counters();
            want.system_subframe = sf[SF_W-1:0];
            want.in_pool         = pool;
            want.pool_index      = pool ? k[IDX_W-1:0] : '1;
            want.pssch_subframe  = pool ? KMOD_W'(k % PSSCH_MOD) : '0;
            pending_maps.push_back(want);
        endfunction

        function void check_map(logic [SF_W-1:0] sf, logic in_pool,
                                logic signed [IDX_W-1:0] idx, logic [KMOD_W-1:0] kmod);
            subframe_map_t want;
            if (pending_maps.size() == 0)
            begin
                map_errors++;
                if (map_errors <= 10)
                    $display("Unexpected result: subframe %0d in_pool %0d index %0d pssch %0d",
                             sf, in_pool, idx, kmod);
                return;
            end
            want = pending_maps.pop_front();
            if (sf !== want.system_subframe || in_pool !== want.in_pool ||
                idx !== want.pool_index || kmod !== want.pssch_subframe)
            begin
                map_errors++;
                if (map_errors <= 10)
                    $display("Mismatch: expected subframe %0d in_pool %0d index %0d pssch %0d, %s",
                             want.system_subframe, want.in_pool, want.pool_index,
                             want.pssch_subframe,
                             $sformatf("got subframe %0d in_pool %0d index %0d pssch %0d",
                                       sf, in_pool, idx, kmod));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sspm_tick_if   tick();
    sspm_result_if result();
    sspm_cfg_if    cfg();

    sidelink_subframe_pool_mapper_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .result (result),
        .cfg    (cfg)
    );

    pool_map_checker pool_map;
    int unsigned     rx_gap_max;
    bit              hold_request;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // A tick's valid stays high into the next request when no gap is drawn.
    task automatic send_tick(input logic restart, input int unsigned gap_max);
        int unsigned gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            tick.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick.valid   <= 1'b1;
        tick.restart <= restart;
        @(posedge clk);
        while (!tick.ready) @(posedge clk);
        pool_map.map_tick(restart);
    endtask

    task automatic wait_for_results();
        tick.valid <= 1'b0;
        @(posedge clk);
        while (pool_map.pending_maps.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        pool_map.write_reg(idx, value);
    endtask

    task automatic apply_settings(input logic [DATA_W-1:0] offset_data, len_data,
                                  low_data, high_data);
        write_reg(CFG_SYNC_OFFSET, offset_data);
        write_reg(CFG_BITMAP_LEN, len_data);
        write_reg(CFG_BITMAP_LOW, low_data);
        write_reg(CFG_BITMAP_HIGH, high_data);
        cfg.valid <= 1'b0;
    endtask

    // Result side: a random stall before each request, and a long hold-off when asked.
    initial
    begin
        int unsigned stall;
        result.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 0;
                result.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
            if (stall != 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
            pool_map.check_map(result.system_subframe, result.in_pool,
                               result.pool_index, result.pssch_subframe);
    end

    // Ends the run when no request of any channel has completed for too long.
    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((tick.valid && tick.ready) || (result.valid && result.ready) ||
                (cfg.valid && cfg.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [DATA_W-1:0] offset_data, len_data, low_data, high_data;
        int unsigned       sent, phase, count, tx_gap_max;
        pool_map     = new();
        rx_gap_max   = 17;
        hold_request = 0;
        rst_n        <= 1'b0;
        tick.valid   <= 1'b0;
        tick.restart <= 1'b0;
        cfg.valid    <= 1'b0;
        cfg.index    <= CFG_SYNC_OFFSET;
        cfg.data     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: sync subframe at offset 0, empty bitmap, nothing reserved.
        send_tick(1'b0, 17);
        send_tick(1'b0, 17);
        send_tick(1'b1, 17);
        wait_for_results();

        // Full bitmap of 100 bits: the first non-sync subframe of a span is reserved.
        apply_settings(64'd3, 64'd100, '1, '1);
        send_tick(1'b1, 17);
        repeat (5) send_tick(1'b0, 17);
        wait_for_results();

        // Offset beyond the sync period and a zero length, changed in mid-span.
        apply_settings(64'd255, 64'd0, 64'h1, '1);
        repeat (4) send_tick(1'b0, 17);
        wait_for_results();

        // Length above 100 and the last sync position.
        apply_settings(64'd159, 64'd127, 64'h8000_0000_0000_0001, 64'h8_0000_0001);
        send_tick(1'b1, 17);
        repeat (3) send_tick(1'b0, 17);
        wait_for_results();

        // An offset equal to the sync period wraps to zero.
        apply_settings(64'd160, 64'd97, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5_5555_5555);
        repeat (5) send_tick(1'b0, 17);
        wait_for_results();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_TICKS)
        begin
            count = $urandom_range(120, 200);
            offset_data = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: offset_data[7:0] = 8'd0;
                1: offset_data[7:0] = 8'd159;
                2: offset_data[7:0] = 8'($urandom_range(160, 255));
                default: offset_data[7:0] = 8'($urandom_range(0, 159));
            endcase
            len_data = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0: len_data[6:0] = 7'd1;
                1: len_data[6:0] = 7'd100;
                2: len_data[6:0] = 7'd0;
                3: len_data[6:0] = 7'($urandom_range(101, 127));
                default: len_data[6:0] = 7'($urandom_range(1, 100));
            endcase
            case ($urandom_range(0, 3))
                0: low_data = '1;
                1: low_data = '0;
                2: low_data = {$urandom, $urandom};
                default: low_data = {$urandom, $urandom} & {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 3))
                0: high_data = '1;
                1: high_data = '0;
                2: high_data = {$urandom, $urandom};
                default: high_data = {$urandom, $urandom} & {$urandom, $urandom};
            endcase
            apply_settings(offset_data, len_data, low_data, high_data);

            tx_gap_max = (phase % 4 == 1) ? 0 : (phase % 4 == 3) ? 3 : 17;
            rx_gap_max = (phase % 4 == 2) ? 0 : 17;
            // The sender keeps offering during the hold-off, so the block backs up.
            if (phase == 3)
                hold_request = 1;
            send_tick(logic'($urandom_range(0, 1)), tx_gap_max);
            repeat (count - 1)
                send_tick(logic'($urandom_range(0, 99) == 0), tx_gap_max);
            wait_for_results();
            sent  = sent + count;
            phase = phase + 1;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pool_map.map_errors == 0 && pool_map.pending_maps.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

/* sim.f */
+incdir+sv
sv/sspm_pkg.sv
sv/sspm_tick_if.sv
sv/sspm_result_if.sv
sv/sspm_cfg_if.sv
sv/sspm_div.sv
sv/sidelink_subframe_pool_mapper_top.sv
tb/tb.sv
